// File: hw/rtl/bemw_pkg.sv
`default_nettype none
package bemw_pkg;

    // field widths
    localparam int TICK_W    = 32;
    localparam int CUR_W     = 23;
    localparam int VOLT_W    = 15;
    localparam int THR_W     = 22;
    localparam int WLEN_W    = 16;
    localparam int SUM_W     = 64;
    localparam int ENERGY_W  = 32;
    localparam int AIR_W     = 27;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 22;

    // current x voltage product, signed
    localparam int PROD_W = CUR_W + VOLT_W;

    // ticks per second is a power of two: divide by it with a shift
    localparam int TICK_SHIFT = 15;

    // energy: sum / (1000 * 32768), taken as (sum >> 15) / 1000
    localparam int DIVIDEND_W = SUM_W - TICK_SHIFT;
    localparam int DIV_CONST  = 1000;
    localparam int REM_W      = 10;

    // airtime: ticks * 1000 >> 15
    localparam int MUL_CONST_W = 10;
    localparam int AIR_PROD_W  = TICK_W + MUL_CONST_W;

    // register reset values
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(25000);
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(3500);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

    // input word kinds
    localparam logic KIND_ARM    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_POST,
        ST_FINISH
    } bemw_state_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } bemw_unit_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/burst_energy_window_meter.sv
`default_nettype none
// Burst energy window meter. An arm word (kind 0) opens a window of
// window_length samples; each sample word (kind 1) inside the window is
// checked against detect_threshold, and current x voltage x tick delta is
// integrated from the first to the last sample at or above it. The last
// sample of the window produces one result word: energy in uJ (saturated
// signed 32 bits), time on air in ms and a burst flag. Words are taken one
// at a time. An arm word and a word outside a window are taken in the idle
// state; a sample inside a window then passes the post state and, once a
// burst has started, first runs the bit-serial multiply-accumulate (15
// voltage bits then 32 tick-delta bits). The closing sample adds the
// bit-serial divide by 1000 (49 quotient bits), plus any wait for the
// previous result word to be taken. Write the registers while idle.
module burst_energy_window_meter (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic        [bemw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [bemw_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_kind,
    input  wire logic        [bemw_pkg::TICK_W-1:0]     s_timestamp,
    input  wire logic signed [bemw_pkg::CUR_W-1:0]      s_current_ua,
    input  wire logic        [bemw_pkg::VOLT_W-1:0]     s_bus_mv,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed      [bemw_pkg::ENERGY_W-1:0]   m_burst_energy,
    output logic             [bemw_pkg::AIR_W-1:0]      m_airtime_ms,
    output logic                                        m_burst_seen
);

    localparam int SAT_W = bemw_pkg::DIVIDEND_W - (bemw_pkg::ENERGY_W - 1);

    bemw_pkg::bemw_state_t state_reg, state_next;

    logic [bemw_pkg::THR_W-1:0]     thr_reg;
    logic [bemw_pkg::WLEN_W-1:0]    wlen_reg;

    logic                           window_open_reg, window_open_next;
    logic [bemw_pkg::WLEN_W-1:0]    samples_left_reg, samples_left_next;
    logic                           span_started_reg, span_started_next;
    logic [bemw_pkg::TICK_W-1:0]    first_tick_reg, first_tick_next;
    logic [bemw_pkg::TICK_W-1:0]    last_tick_reg, last_tick_next;
    logic [bemw_pkg::TICK_W-1:0]    prev_tick_reg, prev_tick_next;
    logic signed [bemw_pkg::CUR_W-1:0] prev_cur_reg, prev_cur_next;
    logic [bemw_pkg::VOLT_W-1:0]    prev_volt_reg, prev_volt_next;
    logic [bemw_pkg::SUM_W-1:0]     running_sum_reg, running_sum_next;
    logic [bemw_pkg::SUM_W-1:0]     committed_sum_reg, committed_sum_next;

    logic [bemw_pkg::TICK_W-1:0]    samp_tick_reg, samp_tick_next;
    logic signed [bemw_pkg::CUR_W-1:0] samp_cur_reg, samp_cur_next;
    logic [bemw_pkg::VOLT_W-1:0]    samp_volt_reg, samp_volt_next;

    logic                           m_valid_reg, m_valid_next;
    logic [bemw_pkg::ENERGY_W-1:0]  m_energy_reg, m_energy_next;
    logic [bemw_pkg::AIR_W-1:0]     m_air_reg, m_air_next;
    logic                           m_seen_reg, m_seen_next;

    logic                           mac_start, fin_start;
    logic                           fin_start_pending;
    bemw_pkg::bemw_unit_sts_t       mac_sts, div_sts, air_sts;
    logic [bemw_pkg::SUM_W-1:0]     mac_acc;
    logic [bemw_pkg::DIVIDEND_W-1:0] div_quo;
    logic [bemw_pkg::AIR_W-1:0]     air_ms;

    logic [bemw_pkg::TICK_W-1:0]    dt;
    logic [bemw_pkg::SUM_W-1:0]     sum_mag;
    logic                           crossed;
    logic                           sat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= bemw_pkg::THR_RESET;
            wlen_reg <= bemw_pkg::WLEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bemw_pkg::CFG_THRESHOLD: thr_reg  <= cfg_wdata[bemw_pkg::THR_W-1:0];
                bemw_pkg::CFG_WINDOW:    wlen_reg <= cfg_wdata[bemw_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // tick delta of the incoming sample, taken as the multiply-accumulate starts
    assign dt      = s_timestamp - prev_tick_reg;
    assign crossed = !samp_cur_reg[bemw_pkg::CUR_W-1] &&
                     (samp_cur_reg[bemw_pkg::CUR_W-2:0] >= thr_reg);
    assign sum_mag = committed_sum_reg[bemw_pkg::SUM_W-1] ?
                     (~committed_sum_reg + 1'b1) : committed_sum_reg;
    assign sat     = (div_quo[bemw_pkg::DIVIDEND_W-1:bemw_pkg::ENERGY_W-1] != SAT_W'(0));

    // next state and datapath control
    always_comb begin
        state_next         = state_reg;
        s_ready            = 1'b0;
        mac_start          = 1'b0;
        fin_start          = 1'b0;
        window_open_next   = window_open_reg;
        samples_left_next  = samples_left_reg;
        span_started_next  = span_started_reg;
        first_tick_next    = first_tick_reg;
        last_tick_next     = last_tick_reg;
        prev_tick_next     = prev_tick_reg;
        prev_cur_next      = prev_cur_reg;
        prev_volt_next     = prev_volt_reg;
        running_sum_next   = running_sum_reg;
        committed_sum_next = committed_sum_reg;
        samp_tick_next     = samp_tick_reg;
        samp_cur_next      = samp_cur_reg;
        samp_volt_next     = samp_volt_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_energy_next      = m_energy_reg;
        m_air_next         = m_air_reg;
        m_seen_next        = m_seen_reg;

        unique case (state_reg)
            bemw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    samp_tick_next = s_timestamp;
                    samp_cur_next  = s_current_ua;
                    samp_volt_next = s_bus_mv;
                    if (s_kind == bemw_pkg::KIND_ARM) begin
                        // open a fresh window
                        window_open_next   = 1'b1;
                        samples_left_next  = wlen_reg;
                        span_started_next  = 1'b0;
                        first_tick_next    = '0;
                        last_tick_next     = '0;
                        prev_tick_next     = '0;
                        prev_cur_next      = '0;
                        prev_volt_next     = '0;
                        running_sum_next   = '0;
                        committed_sum_next = '0;
                    end else if (window_open_reg) begin
                        if (span_started_reg) begin
                            mac_start  = 1'b1;
                            state_next = bemw_pkg::ST_MAC;
                        end else begin
                            state_next = bemw_pkg::ST_POST;
                        end
                    end
                end
            end

            bemw_pkg::ST_MAC: begin
                if (mac_sts.done) begin
                    running_sum_next = mac_acc;
                    state_next       = bemw_pkg::ST_POST;
                end
            end

            bemw_pkg::ST_POST: begin
                // track the span and advance the window count
                if (crossed) begin
                    if (!span_started_reg) begin
                        span_started_next  = 1'b1;
                        first_tick_next    = samp_tick_reg;
                        running_sum_next   = '0;
                        committed_sum_next = '0;
                    end else begin
                        committed_sum_next = running_sum_reg;
                    end
                    last_tick_next = samp_tick_reg;
                end
                prev_tick_next = samp_tick_reg;
                prev_cur_next  = samp_cur_reg;
                prev_volt_next = samp_volt_reg;
                if (samples_left_reg > 1) begin
                    samples_left_next = samples_left_reg - 1'b1;
                    state_next        = bemw_pkg::ST_IDLE;
                end else begin
                    samples_left_next = '0;
                    window_open_next  = 1'b0;
                    state_next        = bemw_pkg::ST_FINISH;
                end
            end

            bemw_pkg::ST_FINISH: begin
                // the pending flag launches the units on entry; load the word once they finish and the output is free
                if (!div_sts.busy && !air_sts.busy && !div_sts.done && !air_sts.done &&
                    !fin_start_pending) begin
                    fin_start = 1'b0;
                end
                if (fin_start_pending) begin
                    fin_start = 1'b1;
                end else if (!div_sts.busy && !air_sts.busy &&
                             (!m_valid_reg || m_ready)) begin
                    m_valid_next = 1'b1;
                    m_seen_next  = span_started_reg;
                    if (!span_started_reg) begin
                        m_energy_next = '0;
                        m_air_next    = '0;
                    end else begin
                        m_air_next = air_ms;
                        if (!committed_sum_reg[bemw_pkg::SUM_W-1]) begin
                            m_energy_next = sat ? {1'b0, {(bemw_pkg::ENERGY_W-1){1'b1}}} :
                                            div_quo[bemw_pkg::ENERGY_W-1:0];
                        end else begin
                            m_energy_next = sat ? {1'b1, {(bemw_pkg::ENERGY_W-1){1'b0}}} :
                                            (~div_quo[bemw_pkg::ENERGY_W-1:0] + 1'b1);
                        end
                    end
                    state_next = bemw_pkg::ST_IDLE;
                end
            end

            default: state_next = bemw_pkg::ST_IDLE;
        endcase
    end

    // launch flag for the closing units, set on entry to the finish state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_start_pending <= 1'b0;
        end else begin
            fin_start_pending <= (state_reg == bemw_pkg::ST_POST) &&
                                 (state_next == bemw_pkg::ST_FINISH);
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= bemw_pkg::ST_IDLE;
            window_open_reg   <= 1'b0;
            samples_left_reg  <= '0;
            span_started_reg  <= 1'b0;
            first_tick_reg    <= '0;
            last_tick_reg     <= '0;
            prev_tick_reg     <= '0;
            prev_cur_reg      <= '0;
            prev_volt_reg     <= '0;
            running_sum_reg   <= '0;
            committed_sum_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            window_open_reg   <= window_open_next;
            samples_left_reg  <= samples_left_next;
            span_started_reg  <= span_started_next;
            first_tick_reg    <= first_tick_next;
            last_tick_reg     <= last_tick_next;
            prev_tick_reg     <= prev_tick_next;
            prev_cur_reg      <= prev_cur_next;
            prev_volt_reg     <= prev_volt_next;
            running_sum_reg   <= running_sum_next;
            committed_sum_reg <= committed_sum_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // sample and result payload
    always_ff @(posedge aclk) begin
        samp_tick_reg <= samp_tick_next;
        samp_cur_reg  <= samp_cur_next;
        samp_volt_reg <= samp_volt_next;
        m_energy_reg  <= m_energy_next;
        m_air_reg     <= m_air_next;
        m_seen_reg    <= m_seen_next;
    end

    bemw_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .cur     (prev_cur_reg),
        .volt    (prev_volt_reg),
        .dt      (dt),
        .acc_in  (running_sum_reg),
        .sts     (mac_sts),
        .acc_out (mac_acc)
    );

    bemw_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (fin_start),
        .dividend (sum_mag[bemw_pkg::SUM_W-1:bemw_pkg::TICK_SHIFT]),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    bemw_air u_air (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fin_start),
        .ticks   (last_tick_reg - first_tick_reg),
        .sts     (air_sts),
        .airtime (air_ms)
    );

    assign m_valid        = m_valid_reg;
    assign m_burst_energy = m_energy_reg;
    assign m_airtime_ms   = m_air_reg;
    assign m_burst_seen   = m_seen_reg;

endmodule
`default_nettype wire

// File: hw/rtl/bemw_mac.sv
`default_nettype none
// Serial multiply-accumulate: acc_out = acc_in + cur * volt * dt (mod 2^64).
// First pass walks the voltage bits, second pass walks the tick delta bits.
module bemw_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic signed [bemw_pkg::CUR_W-1:0]   cur,
    input  wire logic        [bemw_pkg::VOLT_W-1:0]  volt,
    input  wire logic        [bemw_pkg::TICK_W-1:0]  dt,
    input  wire logic        [bemw_pkg::SUM_W-1:0]   acc_in,
    output bemw_pkg::bemw_unit_sts_t                 sts,
    output logic             [bemw_pkg::SUM_W-1:0]   acc_out
);

    localparam int CNT_W = $clog2(bemw_pkg::TICK_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic                          phase_b_reg, phase_b_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [bemw_pkg::SUM_W-1:0]    mcand_reg, mcand_next;
    logic [bemw_pkg::VOLT_W-1:0]   volt_reg, volt_next;
    logic [bemw_pkg::TICK_W-1:0]   dt_reg, dt_next;
    logic [bemw_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [bemw_pkg::SUM_W-1:0]    acc_reg, acc_next;

    // advance one multiplier bit per cycle
    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        phase_b_next = phase_b_reg;
        count_next   = count_reg;
        mcand_next   = mcand_reg;
        volt_next    = volt_reg;
        dt_next      = dt_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        if (start) begin
            busy_next    = 1'b1;
            phase_b_next = 1'b0;
            count_next   = CNT_W'(bemw_pkg::VOLT_W - 1);
            mcand_next   = bemw_pkg::SUM_W'(cur);
            volt_next    = volt;
            dt_next      = dt;
            prod_next    = '0;
            acc_next     = acc_in;
        end else if (busy_reg) begin
            if (!phase_b_reg) begin
                if (volt_reg[0]) begin
                    prod_next = prod_reg + mcand_reg[bemw_pkg::PROD_W-1:0];
                end
                volt_next  = volt_reg >> 1;
                mcand_next = mcand_reg << 1;
                if (count_reg == '0) begin
                    // hand the signed product to the second pass
                    phase_b_next = 1'b1;
                    count_next   = CNT_W'(bemw_pkg::TICK_W - 1);
                    mcand_next   = {{(bemw_pkg::SUM_W - bemw_pkg::PROD_W)
                                     {prod_next[bemw_pkg::PROD_W-1]}}, prod_next};
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end else begin
                if (dt_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                dt_next    = dt_reg >> 1;
                mcand_next = mcand_reg << 1;
                if (count_reg == '0) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        phase_b_reg <= phase_b_next;
        count_reg   <= count_next;
        mcand_reg   <= mcand_next;
        volt_reg    <= volt_next;
        dt_reg      <= dt_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign acc_out  = acc_reg;

endmodule
`default_nettype wire

// File: hw/rtl/bemw_div.sv
`default_nettype none
// Restoring division by a constant, one quotient bit per cycle, MSB first.
module bemw_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [bemw_pkg::DIVIDEND_W-1:0]       dividend,
    output bemw_pkg::bemw_unit_sts_t                   sts,
    output logic      [bemw_pkg::DIVIDEND_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(bemw_pkg::DIVIDEND_W);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [bemw_pkg::DIVIDEND_W-1:0]    shift_reg, shift_next;
    logic [bemw_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [bemw_pkg::REM_W:0]           trial;
    logic                               qbit;

    // shift a dividend bit into the remainder, subtract when it fits
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        trial      = {rem_reg, shift_reg[bemw_pkg::DIVIDEND_W-1]};
        qbit       = (trial >= (bemw_pkg::REM_W+1)'(bemw_pkg::DIV_CONST));
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(bemw_pkg::DIVIDEND_W - 1);
            shift_next = dividend;
            rem_next   = '0;
        end else if (busy_reg) begin
            if (qbit) begin
                rem_next = bemw_pkg::REM_W'(trial -
                           (bemw_pkg::REM_W+1)'(bemw_pkg::DIV_CONST));
            end else begin
                rem_next = trial[bemw_pkg::REM_W-1:0];
            end
            shift_next = {shift_reg[bemw_pkg::DIVIDEND_W-2:0], qbit};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = shift_reg;

endmodule
`default_nettype wire

// File: hw/rtl/bemw_air.sv
`default_nettype none
// Airtime scaler: ticks * 1000 >> 15, shift-add over the constant's bits.
module bemw_air (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [bemw_pkg::TICK_W-1:0]       ticks,
    output bemw_pkg::bemw_unit_sts_t               sts,
    output logic      [bemw_pkg::AIR_W-1:0]        airtime
);

    localparam int CNT_W = $clog2(bemw_pkg::MUL_CONST_W);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [bemw_pkg::MUL_CONST_W-1:0]   k_reg, k_next;
    logic [bemw_pkg::AIR_PROD_W-1:0]    mcand_reg, mcand_next;
    logic [bemw_pkg::AIR_PROD_W-1:0]    acc_reg, acc_next;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        k_next     = k_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = CNT_W'(bemw_pkg::MUL_CONST_W - 1);
            k_next     = bemw_pkg::MUL_CONST_W'(bemw_pkg::DIV_CONST);
            mcand_next = bemw_pkg::AIR_PROD_W'(ticks);
            acc_next   = '0;
        end else if (busy_reg) begin
            if (k_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            k_next     = k_reg >> 1;
            mcand_next = mcand_reg << 1;
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        count_reg <= count_next;
        k_reg     <= k_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign airtime  = acc_reg[bemw_pkg::TICK_SHIFT +: bemw_pkg::AIR_W];

endmodule
`default_nettype wire

// File: sim/tb_top.sv
module tb_top;

    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 1500;

    localparam longint UJ_DIVISOR = 64'sd32768000;
    localparam longint ENERGY_MAX = 64'sd2147483647;
    localparam longint ENERGY_MIN = -64'sd2147483648;

    typedef struct {
        logic                        kind;
        logic [bemw_pkg::TICK_W-1:0] ts;
        logic [bemw_pkg::CUR_W-1:0]  cur;
        logic [bemw_pkg::VOLT_W-1:0] mv;
    } meter_word_t;

    typedef struct packed {
        logic [bemw_pkg::ENERGY_W-1:0] burst_energy;
        logic [bemw_pkg::AIR_W-1:0]    airtime_ms;
        logic                          burst_seen;
    } meter_result_t;

    logic                                 aclk           = 1'b0;
    logic                                 aresetn        = 1'b0;
    logic                                 cfg_we         = 1'b0;
    logic [bemw_pkg::CFG_IDX_W-1:0]       cfg_index      = '0;
    logic [bemw_pkg::CFG_W-1:0]           cfg_wdata      = '0;
    logic                                 s_valid        = 1'b0;
    logic                                 s_ready;
    logic                                 s_kind         = 1'b0;
    logic [bemw_pkg::TICK_W-1:0]          s_timestamp    = '0;
    logic signed [bemw_pkg::CUR_W-1:0]    s_current_ua   = '0;
    logic [bemw_pkg::VOLT_W-1:0]          s_bus_mv       = '0;
    logic                                 m_valid;
    logic                                 m_ready        = 1'b0;
    logic signed [bemw_pkg::ENERGY_W-1:0] m_burst_energy;
    logic [bemw_pkg::AIR_W-1:0]           m_airtime_ms;
    logic                                 m_burst_seen;

    burst_energy_window_meter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_timestamp    (s_timestamp),
        .s_current_ua   (s_current_ua),
        .s_bus_mv       (s_bus_mv),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_burst_energy (m_burst_energy),
        .m_airtime_ms   (m_airtime_ms),
        .m_burst_seen   (m_burst_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // stimulus and expectations
    meter_word_t   words_to_send[$];
    meter_result_t results_due[$];
    meter_word_t   on_bus;
    meter_result_t want;
    bit            word_in_flight = 1'b0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;
    int            hold_req       = 0;
    int            hold_seen      = 0;
    int            hold_left      = 0;
    int            quiet_cycles   = 0;
    int            err_count      = 0;
    logic [bemw_pkg::TICK_W-1:0] ts_now = '0;

    // predictor: configuration and window state
    logic [bemw_pkg::THR_W-1:0]  thr_cfg    = bemw_pkg::THR_RESET;
    logic [bemw_pkg::WLEN_W-1:0] wlen_cfg   = bemw_pkg::WLEN_RESET;
    bit                          win_open   = 1'b0;
    logic [bemw_pkg::WLEN_W-1:0] left       = '0;
    bit                          span_on    = 1'b0;
    logic [bemw_pkg::TICK_W-1:0] t_first    = '0;
    logic [bemw_pkg::TICK_W-1:0] t_last     = '0;
    logic [bemw_pkg::TICK_W-1:0] t_prev     = '0;
    logic [bemw_pkg::CUR_W-1:0]  i_prev     = '0;
    logic [bemw_pkg::VOLT_W-1:0] v_prev     = '0;
    logic [bemw_pkg::SUM_W-1:0]  sum_run    = '0;
    logic [bemw_pkg::SUM_W-1:0]  sum_commit = '0;

    // advance the window state by one accepted word; queue a result on window close
    task automatic integrate_word(input meter_word_t w);
        logic [bemw_pkg::TICK_W-1:0] dt;
        logic [bemw_pkg::SUM_W-1:0]  term;
        logic [bemw_pkg::SUM_W-1:0]  air;
        longint                      quot;
        meter_result_t               r;
        if (w.kind == bemw_pkg::KIND_ARM) begin
            win_open   = 1'b1;
            left       = wlen_cfg;
            span_on    = 1'b0;
            t_first    = '0;
            t_last     = '0;
            t_prev     = '0;
            i_prev     = '0;
            v_prev     = '0;
            sum_run    = '0;
            sum_commit = '0;
        end else if (win_open) begin
            // integrate the previous sample up to this tick, wrapping at 64 bits
            if (span_on) begin
                dt   = w.ts - t_prev;
                term = {{(bemw_pkg::SUM_W-bemw_pkg::CUR_W){i_prev[bemw_pkg::CUR_W-1]}},
                        i_prev}
                     * {{(bemw_pkg::SUM_W-bemw_pkg::VOLT_W){1'b0}}, v_prev}
                     * {{(bemw_pkg::SUM_W-bemw_pkg::TICK_W){1'b0}}, dt};
                sum_run = sum_run + term;
            end
            if (int'($signed(w.cur)) >= int'(thr_cfg)) begin
                if (!span_on) begin
                    span_on = 1'b1;
                    t_first = w.ts;
                    sum_run = '0;
                end
                t_last     = w.ts;
                sum_commit = sum_run;
            end
            t_prev = w.ts;
            i_prev = w.cur;
            v_prev = w.mv;
            if (left != 0)
                left = left - 1'b1;
            // close the window on its last sample
            if (left == 0) begin
                win_open = 1'b0;
                r = '0;
                if (span_on) begin
                    quot = signed'(sum_commit) / UJ_DIVISOR;
                    if (quot > ENERGY_MAX)
                        quot = ENERGY_MAX;
                    else if (quot < ENERGY_MIN)
                        quot = ENERGY_MIN;
                    r.burst_energy = quot[bemw_pkg::ENERGY_W-1:0];
                    air            = ({32'd0, t_last - t_first} * 64'd1000)
                                     >> bemw_pkg::TICK_SHIFT;
                    r.airtime_ms   = air[bemw_pkg::AIR_W-1:0];
                    r.burst_seen   = 1'b1;
                end
                results_due.push_back(r);
            end
        end
    endtask

    // driver: offer queued words, hold each until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                integrate_word(on_bus);
                word_in_flight = 1'b0;
            end
            if (!s_valid || s_ready) begin
                if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus         = words_to_send.pop_front();
                    word_in_flight = 1'b1;
                    s_valid        <= 1'b1;
                    s_kind         <= on_bus.kind;
                    s_timestamp    <= on_bus.ts;
                    s_current_ua   <= on_bus.cur;
                    s_bus_mv       <= on_bus.mv;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result words against the oldest expectation, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no expectation waiting");
                    err_count++;
                end else begin
                    want = results_due.pop_front();
                    if (m_burst_energy !== want.burst_energy) begin
                        $error("burst_energy: expected %0d, actual %0d",
                               $signed(want.burst_energy), m_burst_energy);
                        err_count++;
                    end
                    if (m_airtime_ms !== want.airtime_ms) begin
                        $error("airtime_ms: expected %0d, actual %0d",
                               want.airtime_ms, m_airtime_ms);
                        err_count++;
                    end
                    if (m_burst_seen !== want.burst_seen) begin
                        $error("burst_seen: expected %0d, actual %0d",
                               want.burst_seen, m_burst_seen);
                        err_count++;
                    end
                end
            end
            // start a long hold-off when asked
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: end the run if no word moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("burst_energy_window_meter regression: fail");
                $finish;
            end
        end
    end

    task automatic push_word(input logic kind, input logic [bemw_pkg::TICK_W-1:0] ts,
                             input int cur, input int mv);
        meter_word_t w;
        w.kind = kind;
        w.ts   = ts;
        w.cur  = bemw_pkg::CUR_W'(cur);
        w.mv   = bemw_pkg::VOLT_W'(mv);
        words_to_send.push_back(w);
    endtask

    task automatic queue_arm();
        push_word(bemw_pkg::KIND_ARM, $urandom(), $urandom(), $urandom());
    endtask

    // sample with current clustered around the threshold, ticks mostly close together
    task automatic queue_sample(input logic [bemw_pkg::THR_W-1:0] thr);
        int c;
        int v;
        case ($urandom_range(9))
            0:       ts_now = $urandom();
            1:       ts_now = ts_now + $urandom_range(1 << 20, 1);
            default: ts_now = ts_now + $urandom_range(40, 1);
        endcase
        case ($urandom_range(9))
            0, 1, 2: c = $urandom();
            3:       c = int'(thr);
            4:       c = int'(thr) - 1;
            5, 6: begin
                c = int'(thr) + $urandom_range(2000);
                if (c > 4194303)
                    c = 4194303;
            end
            7:       c = -int'($urandom_range(4194304, 1));
            default: c = int'(thr) - int'($urandom_range(3000));
        endcase
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 32767;
            default: v = $urandom_range(32767);
        endcase
        push_word(bemw_pkg::KIND_SAMPLE, ts_now, c, v);
    endtask

    task automatic write_reg(input logic [bemw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bemw_pkg::CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == bemw_pkg::CFG_THRESHOLD)
            thr_cfg = value[bemw_pkg::THR_W-1:0];
        else
            wlen_cfg = value[bemw_pkg::WLEN_W-1:0];
    endtask

    // wait until every word is taken and every result has come, then let the block settle
    task automatic wait_idle();
        while (words_to_send.size() != 0 || word_in_flight || results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // windows with random content, some cut short by a new arm, a few stray samples
    task automatic random_phase(input logic [bemw_pkg::THR_W-1:0] thr,
                                input logic [bemw_pkg::WLEN_W-1:0] wlen,
                                input int n_items, input bit hold_rx);
        int made;
        int n;
        int pick;
        wait_idle();
        write_reg(bemw_pkg::CFG_THRESHOLD, bemw_pkg::CFG_W'(thr));
        write_reg(bemw_pkg::CFG_WINDOW, bemw_pkg::CFG_W'(wlen));
        if (hold_rx)
            hold_req++;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                queue_sample(thr);
            end else begin
                n = (wlen == 0) ? 1 : int'(wlen);
                if (pick < 14 && n > 1)
                    n = $urandom_range(n - 1, 1);
                queue_arm();
                repeat (n) queue_sample(thr);
                made += n + 1;
            end
        end
    endtask

    initial begin
        send_idle_pct = 16;
        recv_idle_pct = 88;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // threshold keeps its reset value here
        write_reg(bemw_pkg::CFG_WINDOW, bemw_pkg::CFG_W'(4));
        // stray sample with no window open
        push_word(bemw_pkg::KIND_SAMPLE, 32'hFFFF_FFFF, 4194303, 32767);
        // crossing at the threshold, negative current, tick wrap inside the span
        push_word(bemw_pkg::KIND_ARM, 32'h0000_0000, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 32'hFFFF_FF00, 24999, 100);
        push_word(bemw_pkg::KIND_SAMPLE, 32'hFFFF_FF10, 25000, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 32'h0000_0040, -4194304, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 32'h0000_0100, 4194303, 0);
        // no crossing in the window
        push_word(bemw_pkg::KIND_ARM, 32'hFFFF_FFFF, -1, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 10, -1, 5000);
        push_word(bemw_pkg::KIND_SAMPLE, 20, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 30, 24999, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 40, -4194304, 1);
        // re-arm drops the open window
        push_word(bemw_pkg::KIND_ARM, 0, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 100, 30000, 3300);
        push_word(bemw_pkg::KIND_ARM, 0, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 200, 25000, 3300);
        push_word(bemw_pkg::KIND_SAMPLE, 201, 0, 3300);
        push_word(bemw_pkg::KIND_SAMPLE, 202, 25000, 3300);
        push_word(bemw_pkg::KIND_SAMPLE, 203, 1, 1);
        // energy past the positive limit
        push_word(bemw_pkg::KIND_ARM, 0, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 0, 25000, 1000);
        push_word(bemw_pkg::KIND_SAMPLE, 1, 4194303, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 1000001, 25000, 1);
        push_word(bemw_pkg::KIND_SAMPLE, 1000002, 0, 0);
        // energy past the negative limit
        push_word(bemw_pkg::KIND_ARM, 0, 0, 0);
        push_word(bemw_pkg::KIND_SAMPLE, 0, 25000, 1);
        push_word(bemw_pkg::KIND_SAMPLE, 1, -4194304, 32767);
        push_word(bemw_pkg::KIND_SAMPLE, 1000001, 25000, 1);
        push_word(bemw_pkg::KIND_SAMPLE, 1000002, 0, 0);

        random_phase(22'd1000, 16'd3, 120, 1'b0);
        // one-sample windows under a long receiver hold-off fill the block
        random_phase(22'd0, 16'd1, 80, 1'b1);
        random_phase(22'd4194303, 16'd2, 60, 1'b0);

        send_idle_pct = 88;
        recv_idle_pct = 16;
        random_phase(bemw_pkg::THR_W'($urandom_range(60000)), 16'd5, 120, 1'b0);
        // zero length acts as a window of one sample
        random_phase(22'd25000, 16'd0, 40, 1'b0);

        // longest window never closes: samples and a re-arm, no result
        wait_idle();
        write_reg(bemw_pkg::CFG_THRESHOLD, bemw_pkg::CFG_W'(3000));
        write_reg(bemw_pkg::CFG_WINDOW, bemw_pkg::CFG_W'(16'hFFFF));
        queue_arm();
        repeat (30) queue_sample(22'd3000);
        queue_arm();
        repeat (10) queue_sample(22'd3000);

        random_phase(22'd200000, 16'd8, 120, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(bemw_pkg::THR_W'($urandom_range(60000)),
                     bemw_pkg::WLEN_W'($urandom_range(6, 1)), 150, 1'b0);
        random_phase(22'd4194303, 16'd1, 30, 1'b0);

        wait_idle();
        if (err_count == 0)
            $display("burst_energy_window_meter regression: pass");
        else
            $display("burst_energy_window_meter regression: fail");
        $finish;
    end

endmodule
